@@ src/assert_macros.svh @@
// Assertion macros used by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IFF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define IFF_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ src/iff_pkg.sv @@
// Types, constants and helpers for the integer field formatter.
package iff_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 63;
	localparam int unsigned FW_W          = 6;
	localparam int unsigned VALUE_W       = 16;
	localparam int unsigned KIND_W        = 3;
	localparam int unsigned LEN_W         = 4;
	localparam int unsigned BUF_DEPTH     = 8;
	localparam int unsigned BUF_IDX_W     = 3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef enum logic [KIND_W-1:0] {
		KIND_SDEC   = 3'd0,
		KIND_UDEC   = 3'd1,
		KIND_OCT    = 3'd2,
		KIND_HEX_LO = 3'd3,
		KIND_HEX_UP = 3'd4,
		KIND_CHAR   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		RADIX_10 = 2'd0,
		RADIX_8  = 2'd1,
		RADIX_16 = 2'd2
	} radix_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_CONV = 3'd1,
		ST_SIGN = 3'd2,
		ST_PLAN = 3'd3,
		ST_PRE  = 3'd4,
		ST_TEXT = 3'd5,
		ST_POST = 3'd6
	} state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] quot;
		logic [3:0]         rem;
	} div_res_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] d8;
		d8 = {4'b0000, d};
		if (d < 4'd10)
			return CH_ZERO + d8;
		else if (upper)
			return 8'h41 + d8 - 8'd10;
		else
			return 8'h61 + d8 - 8'd10;
	endfunction

endpackage

@@ src/iff_radix_div.sv @@
// Shared divide-by-radix unit: one digit step for radix 10, 8 or 16.
module iff_radix_div
	import iff_pkg::*;
(
	input  logic [VALUE_W-1:0] num,
	input  radix_t             radix,
	output div_res_t           res
);

	logic [31:0]        prod;
	logic [VALUE_W-1:0] q10;
	logic [VALUE_W-1:0] back10;
	logic [VALUE_W-1:0] r10;

	// x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
	assign prod   = {16'h0000, num} * 32'h0000CCCD;
	assign q10    = {3'b000, prod[31:19]};
	assign back10 = {q10[VALUE_W-4:0], 3'b000} + {q10[VALUE_W-2:0], 1'b0};
	assign r10    = num - back10;

	always_comb begin
		case (radix)
			RADIX_10: begin
				res.quot = q10;
				res.rem  = r10[3:0];
			end
			RADIX_8: begin
				res.quot = {3'b000, num[VALUE_W-1:3]};
				res.rem  = {1'b0, num[2:0]};
			end
			RADIX_16: begin
				res.quot = {4'b0000, num[VALUE_W-1:4]};
				res.rem  = num[3:0];
			end
			default: begin
				res.quot = '0;
				res.rem  = '0;
			end
		endcase
	end

endmodule

@@ src/integer_field_formatter_unit.sv @@
// After a request is accepted, the sequencer takes one digit per step from the shared radix
// divider (up to 6 digits), writes a sign if one is needed, plans the padding and then streams
// the field through the output register; a character request skips the digit steps.
// Throughput: one character per cycle once the field streams, while m_tready does not stall the
// output; s_tready is low until the last character of the field is in the output register.
// Unused kinds are accepted and give no output.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and empties the output stage.
module integer_field_formatter_unit
	import iff_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// value[15:0], field_width[21:16], left_justify[22], force_sign[23], space_sign[24],
	// zero_pad[25], zero fill[31:26]
	input  logic [31:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_char[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

`include "assert_macros.svh"

	localparam logic [FW_W-1:0] WMAX = FW_W'(MAX_WIDTH);

	state_t state_q, state_d;

	logic [VALUE_W-1:0] num_q;
	radix_t             radix_q;
	logic               upper_q;
	logic               sign_need_q;
	logic [7:0]         sign_char_q;
	logic               left_q;
	logic [7:0]         padc_q;
	logic [FW_W-1:0]    width_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   txt_q;
	logic [BUF_IDX_W-1:0] rd_q;
	logic [FW_W-1:0]    pad_q;
	logic [7:0]         buf_q [BUF_DEPTH];

	div_res_t           div_res;
	logic               accept;
	logic               emit_en;
	logic               out_load;
	logic [7:0]         out_char;
	logic               out_last;
	kind_t              in_kind;
	logic [VALUE_W-1:0] in_value;
	logic [FW_W-1:0]    in_fw;
	logic               in_neg;
	logic [VALUE_W-1:0] in_num;
	radix_t             in_radix;
	logic               in_sign_need;
	logic [7:0]         in_sign_char;
	logic [LEN_W-1:0]   in_len;
	logic [BUF_IDX_W-1:0] wr_idx;
	logic [LEN_W-1:0]   rd_start;
	logic [FW_W-1:0]    len_ext;
	logic [FW_W-1:0]    padn;

	iff_radix_div u_div (
		.num   (num_q),
		.radix (radix_q),
		.res   (div_res)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign emit_en  = !m_tvalid || m_tready;

	assign in_kind  = kind_t'(s_tuser);
	assign in_value = s_tdata[15:0];
	assign in_fw    = s_tdata[21:16];
	assign in_neg   = in_value[VALUE_W-1];

	assign in_num       = (in_kind == KIND_SDEC && in_neg) ? (VALUE_W'(0) - in_value) : in_value;
	assign in_radix     = (in_kind == KIND_OCT) ? RADIX_8 :
		((in_kind inside {KIND_HEX_LO, KIND_HEX_UP}) ? RADIX_16 : RADIX_10);
	assign in_sign_need = (in_kind == KIND_SDEC) && (s_tdata[23] || in_neg || s_tdata[24]);
	assign in_sign_char = in_neg ? CH_MINUS : (s_tdata[23] ? CH_PLUS : CH_SPACE);
	assign in_len       = (in_kind == KIND_CHAR) ? LEN_W'(1) : '0;

	assign wr_idx   = BUF_IDX_W'(LEN_W'(BUF_DEPTH - 1) - len_q);
	assign rd_start = LEN_W'(BUF_DEPTH) - len_q;
	assign len_ext  = {{(FW_W-LEN_W){1'b0}}, len_q};
	assign padn     = (width_q > len_ext) ? (width_q - len_ext) : '0;

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_char = CH_SPACE;
		out_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_kind) inside
						KIND_SDEC, KIND_UDEC, KIND_OCT, KIND_HEX_LO, KIND_HEX_UP:
							state_d = ST_CONV;
						KIND_CHAR:
							state_d = ST_PLAN;
						default:
							state_d = ST_IDLE;
					endcase
				end
			end
			ST_CONV: begin
				if (div_res.quot == '0)
					state_d = sign_need_q ? ST_SIGN : ST_PLAN;
			end
			ST_SIGN: state_d = ST_PLAN;
			ST_PLAN: state_d = (!left_q && padn != '0) ? ST_PRE : ST_TEXT;
			ST_PRE: begin
				out_char = padc_q;
				if (emit_en) begin
					out_load = 1'b1;
					if (pad_q == FW_W'(1))
						state_d = ST_TEXT;
				end
			end
			ST_TEXT: begin
				out_char = buf_q[rd_q];
				out_last = (txt_q == LEN_W'(1)) && (!left_q || pad_q == '0);
				if (emit_en) begin
					out_load = 1'b1;
					if (txt_q == LEN_W'(1))
						state_d = (left_q && pad_q != '0) ? ST_POST : ST_IDLE;
				end
			end
			ST_POST: begin
				out_char = CH_SPACE;
				out_last = (pad_q == FW_W'(1));
				if (emit_en) begin
					out_load = 1'b1;
					if (pad_q == FW_W'(1))
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					len_q       <= in_len;
					left_q      <= s_tdata[22];
					padc_q      <= (s_tdata[25] && !s_tdata[22]) ? CH_ZERO : CH_SPACE;
					width_q     <= (in_fw > WMAX) ? WMAX : in_fw;
					upper_q     <= (in_kind == KIND_HEX_UP);
					sign_need_q <= in_sign_need;
					sign_char_q <= in_sign_char;
					num_q       <= in_num;
					radix_q     <= in_radix;
					if (in_kind == KIND_CHAR)
						buf_q[BUF_DEPTH-1] <= in_value[7:0];
				end
			end
			ST_CONV: begin
				buf_q[wr_idx] <= digit_char(div_res.rem, upper_q);
				num_q         <= div_res.quot;
				len_q         <= len_q + LEN_W'(1);
			end
			ST_SIGN: begin
				buf_q[wr_idx] <= sign_char_q;
				len_q         <= len_q + LEN_W'(1);
			end
			ST_PLAN: begin
				rd_q  <= rd_start[BUF_IDX_W-1:0];
				txt_q <= len_q;
				pad_q <= padn;
			end
			ST_PRE, ST_POST: begin
				if (emit_en)
					pad_q <= pad_q - FW_W'(1);
			end
			ST_TEXT: begin
				if (emit_en) begin
					rd_q  <= rd_q + BUF_IDX_W'(1);
					txt_q <= txt_q - LEN_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (out_load)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= out_char;
			m_tlast <= out_last;
		end
	end

	`IFF_ASSERT(a_conv_nonzero, (state_q == ST_CONV && len_q != '0) |-> (num_q != '0),
		"digit loop runs on a zero quotient")
	`IFF_ASSERT(a_text_len, (state_q == ST_TEXT) |-> (txt_q != '0 && txt_q <= len_q),
		"text counter out of range")
	`IFF_ASSERT_NEXT(a_pre_right, (state_q == ST_PLAN), (state_q != ST_PRE || !left_q),
		"leading pad on a left-justified field")
	`IFF_ASSERT(a_busy_ready, (state_q != ST_IDLE) |-> !s_tready,
		"request taken while a field is in progress")

endmodule

@@ bench/tb.sv @@
// Testbench for integer_field_formatter_unit: random and directed requests checked per character.
module tb;
	import iff_pkg::*;

	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;
	localparam string DIGITS_LO = "0123456789abcdef";
	localparam string DIGITS_UP = "0123456789ABCDEF";
	localparam int RANDOM_FIELDS = 157;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 500;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [15:0] value;
		logic [2:0]  kind;
		logic [5:0]  width;
		logic        left;
		logic        fsign;
		logic        ssign;
		logic        zpad;
	} field_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} field_char_t;

	class field_scoreboard;
		field_char_t expected[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		task report_mismatch(input string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", msg);
		endtask

		// build the padded field for one accepted request
		function void note_request(input logic [31:0] data, input logic [2:0] kind);
			logic [15:0] value;
			logic [5:0]  width;
			logic        left, fsign, ssign, zpad, neg, upper;
			logic [16:0] mag;
			logic [7:0]  text[$];
			logic [7:0]  padc, ch;
			int unsigned num, radix, len, total, padn;
			field_char_t e;
			value = data[15:0];
			width = data[21:16];
			left  = data[22];
			fsign = data[23];
			ssign = data[24];
			zpad  = data[25];
			upper = 1'b0;
			neg   = 1'b0;
			radix = 10;
			num   = 32'(value);
			case (kind)
				KIND_SDEC: begin
					neg = value[15];
					mag = neg ? (17'h10000 - {1'b0, value}) : {1'b0, value};
					num = 32'(mag);
				end
				KIND_UDEC:   radix = 10;
				KIND_OCT:    radix = 8;
				KIND_HEX_LO: radix = 16;
				KIND_HEX_UP: begin
					radix = 16;
					upper = 1'b1;
				end
				KIND_CHAR: text.push_back(value[7:0]);
				default: return;
			endcase
			if (kind != KIND_CHAR) begin
				do begin
					text.push_front(upper ? DIGITS_UP[num % radix] : DIGITS_LO[num % radix]);
					num = num / radix;
				end while (num != 0);
			end
			if (kind == KIND_SDEC) begin
				if (fsign)
					text.push_front(neg ? CH_MINUS : CH_PLUS);
				else if (neg)
					text.push_front(CH_MINUS);
				else if (ssign)
					text.push_front(CH_SPACE);
			end
			len   = text.size();
			total = (len < width) ? width : len;
			padn  = total - len;
			padc  = (zpad && !left) ? CH_ZERO : CH_SPACE;
			for (int k = 0; k < total; k++) begin
				if (!left)
					ch = (k < padn) ? padc : text[k - padn];
				else
					ch = (k < len) ? text[k] : CH_SPACE;
				e.ch   = ch;
				e.last = (k + 1 == total);
				expected.push_back(e);
			end
		endfunction

		task check_char(input logic [7:0] ch, input logic last);
			field_char_t e;
			if (expected.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h last %b", ch, last));
				return;
			end
			e = expected.pop_front();
			if (ch !== e.ch)
				report_mismatch($sformatf("char %h, want %h", ch, e.ch));
			if (last !== e.last)
				report_mismatch($sformatf("last %b, want %b on char %h", last, e.last, e.ch));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	field_scoreboard sb = new();

	integer_field_formatter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic field_req_t mk_req(input logic [15:0] value, input logic [2:0] kind,
			input logic [5:0] width, input logic left, input logic fsign, input logic ssign,
			input logic zpad);
		field_req_t r;
		r.value = value;
		r.kind  = kind;
		r.width = width;
		r.left  = left;
		r.fsign = fsign;
		r.ssign = ssign;
		r.zpad  = zpad;
		return r;
	endfunction

	task automatic send_request(input field_req_t r, input bit quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, r.zpad, r.ssign, r.fsign, r.left, r.width, r.value};
		s_tuser  <= r.kind;
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				sb.check_char(m_tdata, m_tlast);
		end
	end

	// receiver: random stalls, quiet stretches, one long hold-off
	initial begin
		int n;
		int gap;
		n = 0;
		m_tready <= 1'b0;
		forever begin
			gap = (((n / 40) % 4) == 2) ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			n++;
			if (n == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin
		field_req_t directed[$];
		field_req_t r;
		int sent;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= KIND_SDEC;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(mk_req(16'h0000, KIND_SDEC,   6'd0,  1'b0, 1'b0, 1'b0, 1'b0));
		directed.push_back(mk_req(16'h7FFF, KIND_SDEC,   6'd0,  1'b0, 1'b1, 1'b0, 1'b0));
		directed.push_back(mk_req(16'h8000, KIND_SDEC,   6'd0,  1'b0, 1'b0, 1'b0, 1'b0));
		directed.push_back(mk_req(16'hFFFF, KIND_SDEC,   6'd2,  1'b0, 1'b0, 1'b1, 1'b0));
		directed.push_back(mk_req(16'h0005, KIND_SDEC,   6'd4,  1'b0, 1'b0, 1'b1, 1'b1));
		directed.push_back(mk_req(16'h8000, KIND_SDEC,   6'd10, 1'b0, 1'b1, 1'b0, 1'b1));
		directed.push_back(mk_req(16'd123,  KIND_SDEC,   6'd8,  1'b1, 1'b0, 1'b0, 1'b1));
		directed.push_back(mk_req(16'd12345, KIND_SDEC,  6'd3,  1'b0, 1'b1, 1'b1, 1'b1));
		directed.push_back(mk_req(16'h8000, KIND_SDEC,   6'd63, 1'b1, 1'b0, 1'b1, 1'b0));
		directed.push_back(mk_req(16'hFFFF, KIND_UDEC,   6'd63, 1'b0, 1'b0, 1'b0, 1'b1));
		directed.push_back(mk_req(16'h0000, KIND_UDEC,   6'd0,  1'b0, 1'b1, 1'b1, 1'b0));
		directed.push_back(mk_req(16'hFFFF, KIND_OCT,    6'd0,  1'b0, 1'b1, 1'b0, 1'b0));
		directed.push_back(mk_req(16'h0008, KIND_OCT,    6'd6,  1'b0, 1'b0, 1'b0, 1'b1));
		directed.push_back(mk_req(16'hABCD, KIND_HEX_LO, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0));
		directed.push_back(mk_req(16'hABCD, KIND_HEX_UP, 6'd7,  1'b1, 1'b0, 1'b0, 1'b0));
		directed.push_back(mk_req(16'h0000, KIND_HEX_UP, 6'd1,  1'b0, 1'b0, 1'b0, 1'b0));
		directed.push_back(mk_req(16'h0007, KIND_HEX_LO, 6'd63, 1'b0, 1'b1, 1'b1, 1'b1));
		directed.push_back(mk_req(16'h1241, KIND_CHAR,   6'd0,  1'b0, 1'b0, 1'b0, 1'b0));
		directed.push_back(mk_req(16'h0000, KIND_CHAR,   6'd3,  1'b0, 1'b0, 1'b0, 1'b1));
		directed.push_back(mk_req(16'hFF80, KIND_CHAR,   6'd63, 1'b1, 1'b1, 1'b1, 1'b1));
		directed.push_back(mk_req(16'h1234, KIND_RSVD6,  6'd5,  1'b0, 1'b0, 1'b0, 1'b0));
		directed.push_back(mk_req(16'hFFFF, KIND_RSVD7,  6'd63, 1'b1, 1'b1, 1'b1, 1'b1));
		directed.push_back(mk_req(16'hFFFE, KIND_UDEC,   6'd2,  1'b0, 1'b0, 1'b0, 1'b0));
		foreach (directed[i])
			send_request(directed[i], 1'b0);

		sent = 0;
		while (sent < RANDOM_FIELDS) begin
			case ($urandom_range(0, 7))
				0: r.value = 16'h0000;
				1: r.value = 16'hFFFF;
				2: r.value = 16'h8000;
				3: r.value = 16'h7FFF;
				4: r.value = 16'($urandom_range(0, 20));
				default: r.value = 16'($urandom);
			endcase
			if ($urandom_range(0, 11) == 0)
				r.kind = $urandom_range(0, 1) ? KIND_RSVD6 : KIND_RSVD7;
			else
				r.kind = 3'($urandom_range(KIND_SDEC, KIND_CHAR));
			case ($urandom_range(0, 9))
				0: r.width = 6'($urandom_range(0, 63));
				1, 2: r.width = 6'($urandom_range(0, 20));
				default: r.width = 6'($urandom_range(0, 10));
			endcase
			r.left  = 1'($urandom);
			r.fsign = 1'($urandom);
			r.ssign = 1'($urandom);
			r.zpad  = 1'($urandom);
			send_request(r, sent >= 60 && sent < 90);
			sent++;
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
